// ----- hdl/lpr_pkg.sv -----
// Shared types and constants for the length-prefixed receive ring.
// Used by the ring core; depends on nothing.
package lpr_pkg;

   // default sizing
   localparam int DefaultRingDepth   = 64;
   localparam int DefaultLengthBytes = 2;

   // request opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // response status codes
   localparam logic [2:0] ST_PUSHED    = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_PAYLOAD   = 3'd2;
   localparam logic [2:0] ST_NOT_READY = 3'd3;
   localparam logic [2:0] ST_ZERO_LEN  = 3'd4;

   // one response item as held in the output stages
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] payload_byte;
      logic       last;
      logic [6:0] fill_level;
   } rsp_entry_type;

endpackage

// ----- hdl/lpr_req_if.sv -----
// Request channel of the receive ring: valid/ready plus opcode and byte.
// Standalone; does not depend on lpr_pkg.
interface lpr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// ----- hdl/lpr_rsp_if.sv -----
// Response channel of the receive ring: valid/ready plus status fields.
// Standalone; widths follow the fixed response format.
interface lpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] payload_byte;
   logic       last;
   logic [6:0] fill_level;

   modport source (output valid, output status, output payload_byte,
                   output last, output fill_level, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input last, input fill_level, output ready);
endinterface

// ----- hdl/length_prefixed_receive_ring_core.sv -----
// Length-prefixed receive ring: top level. Uses lpr_pkg, lpr_req_if and lpr_rsp_if.
// Holds the byte ring memory, the pull sequencer and the response skid stage.
//
// A push stores one byte per transfer and returns one response; pushes are taken
// back to back at one per cycle while the response side keeps up. A pull reads the
// LENGTH_BYTES little-endian header bytes through the single registered read port
// of the ring memory (one byte per cycle), checks the length, then streams one
// payload byte per cycle while the output stages have room, marking the last. The
// next request is taken only once the last payload byte has been read and no
// response waits in the read or skid register. A pull that finds too little data
// or a zero length returns a single response and consumes nothing. Responses are
// held in an output register backed by one skid register, so stalls on the
// response side never lose or repeat a transfer.
module length_prefixed_receive_ring_core
   import lpr_pkg::*;
#(
   parameter int RING_DEPTH   = DefaultRingDepth,
   parameter int LENGTH_BYTES = DefaultLengthBytes
) (
   input logic         clock,
   input logic         reset,
   lpr_req_if.sink     req,
   lpr_rsp_if.source   rsp
);

   localparam int IdxW = $clog2(RING_DEPTH);
   localparam int CntW = $clog2(RING_DEPTH + 1);
   localparam int HcW  = $clog2(LENGTH_BYTES + 1);
   localparam int LenW = 8 * LENGTH_BYTES;

   localparam logic [IdxW-1:0] LastPos   = IdxW'(RING_DEPTH - 1);
   localparam logic [CntW-1:0] DepthCnt  = CntW'(RING_DEPTH);
   localparam logic [CntW-1:0] HdrCnt    = CntW'(LENGTH_BYTES);
   localparam logic [HcW-1:0]  HdrBytes  = HcW'(LENGTH_BYTES);
   localparam logic [HcW-1:0]  HdrLast   = HcW'(LENGTH_BYTES - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_HDR    = 2'd1;
   localparam logic [1:0] S_CHECK  = 2'd2;
   localparam logic [1:0] S_STREAM = 2'd3;

   function automatic logic [IdxW-1:0] next_pos(input logic [IdxW-1:0] p);
      return (p == LastPos) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [6:0] fill7(input logic [CntW-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[6:0];
   endfunction

   // ring memory and its registered read data
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] mem_q_ff;
   logic            rd_en, wr_en;
   logic [IdxW-1:0] rd_addr;

   // control state
   logic [1:0]      state_ff, state_in;
   logic [IdxW-1:0] read_index_ff, read_index_in;
   logic [IdxW-1:0] write_index_ff, write_index_in;
   logic [CntW-1:0] free_ff, free_in;
   logic [IdxW-1:0] rd_pos_ff, rd_pos_in;
   logic [HcW-1:0]  iss_ff, iss_in;
   logic [HcW-1:0]  got_ff, got_in;
   logic            hv_ff, hv_in;
   logic [31:0]     len_ff, len_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [CntW-1:0] rem_ff, rem_in;
   logic [CntW-1:0] rel_fill_ff, rel_fill_in;
   logic            pend_v_ff, pend_v_in;
   logic            pend_last_ff, pend_last_in;
   logic [CntW-1:0] pend_fill_ff, pend_fill_in;

   // output register and skid register
   rsp_entry_type out_ff, skid_ff;
   logic          out_v_ff, skid_v_ff;

   logic          e_valid;
   rsp_entry_type e;
   logic          pop, accept, room;
   logic [1:0]    occ;
   logic [CntW-1:0] stored, avail;
   logic [LenW-1:0] len_val;

   assign stored  = DepthCnt - free_ff;
   assign avail   = stored - HdrCnt;
   assign len_val = LenW'(len_ff >> (32 - LenW));

   assign pop    = out_v_ff & rsp.ready;
   assign occ    = 2'(out_v_ff) + 2'(skid_v_ff) + 2'(pend_v_ff);
   assign room   = (occ - 2'(pop)) < 2'd2;
   assign req.ready = (state_ff == S_IDLE) & ~skid_v_ff & ~pend_v_ff;
   assign accept = req.valid & req.ready;

   // sequencer: request decode, header read, length check, payload stream
   always_comb begin
      state_in       = state_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      free_in        = free_ff;
      rd_pos_in      = rd_pos_ff;
      iss_in         = iss_ff;
      got_in         = got_ff;
      hv_in          = 1'b0;
      len_in         = len_ff;
      n_in           = n_ff;
      rem_in         = rem_ff;
      rel_fill_in    = rel_fill_ff;
      pend_v_in      = 1'b0;
      pend_last_in   = pend_last_ff;
      pend_fill_in   = pend_fill_ff;
      rd_en          = 1'b0;
      rd_addr        = rd_pos_ff;
      wr_en          = 1'b0;
      e_valid        = 1'b0;
      e              = '{status: ST_PUSHED, payload_byte: 8'd0, last: 1'b1,
                         fill_level: fill7(stored)};

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = read_index_ff;
            if (accept) begin
               e_valid = 1'b1;
               if (req.op == OP_PUSH) begin
                  if (free_ff == '0) begin
                     e.status = ST_FULL;
                  end else begin
                     wr_en          = 1'b1;
                     write_index_in = next_pos(write_index_ff);
                     free_in        = free_ff - 1'b1;
                     e.fill_level   = fill7(stored + 1'b1);
                  end
               end else if (stored <= HdrCnt) begin
                  e.status = ST_NOT_READY;
               end else begin
                  // start the header read at the oldest byte
                  e_valid   = 1'b0;
                  rd_en     = 1'b1;
                  hv_in     = 1'b1;
                  rd_pos_in = next_pos(read_index_ff);
                  iss_in    = HcW'(1);
                  got_in    = '0;
                  len_in    = '0;
                  state_in  = S_HDR;
               end
            end
         end
         S_HDR: begin
            if (iss_ff != HdrBytes) begin
               rd_en     = 1'b1;
               hv_in     = 1'b1;
               rd_pos_in = next_pos(rd_pos_ff);
               iss_in    = iss_ff + 1'b1;
            end
            // shift header bytes in from the top, least significant first
            if (hv_ff) begin
               len_in = {mem_q_ff, len_ff[31:8]};
               got_in = got_ff + 1'b1;
               if (got_ff == HdrLast) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (!skid_v_ff) begin
               if (len_val == '0) begin
                  e_valid  = 1'b1;
                  e.status = ST_ZERO_LEN;
                  state_in = S_IDLE;
               end else if (32'(avail) < 32'(len_val)) begin
                  e_valid  = 1'b1;
                  e.status = ST_NOT_READY;
                  state_in = S_IDLE;
               end else begin
                  n_in        = CntW'(len_val);
                  rem_in      = CntW'(len_val);
                  rel_fill_in = avail - CntW'(len_val);
                  state_in    = S_STREAM;
               end
            end
         end
         S_STREAM: begin
            if (room) begin
               rd_en        = 1'b1;
               pend_v_in    = 1'b1;
               rd_pos_in    = next_pos(rd_pos_ff);
               rem_in       = rem_ff - 1'b1;
               pend_last_in = (rem_ff == CntW'(1));
               pend_fill_in = stored;
               if (rem_ff == CntW'(1)) begin
                  // release header and payload together
                  pend_fill_in  = rel_fill_ff;
                  read_index_in = next_pos(rd_pos_ff);
                  free_in       = free_ff + HdrCnt + n_ff;
                  state_in      = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // payload byte returning from the ring memory
      if (pend_v_ff) begin
         e_valid = 1'b1;
         e       = '{status: ST_PAYLOAD, payload_byte: mem_q_ff,
                     last: pend_last_ff, fill_level: fill7(pend_fill_ff)};
      end
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[write_index_ff] <= req.data_byte;
      end
      if (rd_en) begin
         mem_q_ff <= ring_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         read_index_ff  <= '0;
         write_index_ff <= '0;
         free_ff        <= DepthCnt;
         hv_ff          <= 1'b0;
         pend_v_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         free_ff        <= free_in;
         hv_ff          <= hv_in;
         pend_v_ff      <= pend_v_in;
      end
   end

   // sequencer working registers
   always_ff @(posedge clock) begin
      rd_pos_ff    <= rd_pos_in;
      iss_ff       <= iss_in;
      got_ff       <= got_in;
      len_ff       <= len_in;
      n_ff         <= n_in;
      rem_ff       <= rem_in;
      rel_fill_ff  <= rel_fill_in;
      pend_last_ff <= pend_last_in;
      pend_fill_ff <= pend_fill_in;
   end

   // output register with skid: advance on transfer, park in skid when stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            out_v_ff  <= 1'b1;
            skid_ff   <= e;
            skid_v_ff <= e_valid;
         end else begin
            out_ff   <= e;
            out_v_ff <= e_valid;
         end
      end else if (e_valid) begin
         skid_ff   <= e;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.status       = out_ff.status;
   assign rsp.payload_byte = out_ff.payload_byte;
   assign rsp.last         = out_ff.last;
   assign rsp.fill_level   = out_ff.fill_level;

endmodule
